### hdl/ttpp_pkg.sv
// shared types, constants and helpers for the tiled texture pixel packer
// no dependencies; imported by ttpp_pack and tiled_texture_pixel_packer_top
`timescale 1ns / 1ps

package ttpp_pkg;

  // field widths
  localparam int unsigned PosW      = 10;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned IndexW    = 20;
  localparam int unsigned WordW     = 32;
  localparam int unsigned FmtW      = 2;
  localparam int unsigned WLog2W    = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 4;

  // padded width limits, log2
  localparam int unsigned MinSizeLog2 = 3;
  localparam int unsigned MaxSizeLog2 = 10;

  // tile geometry: 8x8 tiles, 64 elements each
  localparam int unsigned TileLog2   = 3;
  localparam int unsigned MortonW    = 2 * TileLog2;
  localparam int unsigned TileNumW   = IndexW - MortonW;
  localparam int unsigned ShamtW     = 3;

  typedef enum logic [FmtW-1:0] {
    FMT_RGBA8    = 2'd0,
    FMT_RGBA4444 = 2'd1,
    FMT_RGB565   = 2'd2,
    FMT_RSVD     = 2'd3
  } fmt_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIXEL_FORMAT = 2'd0,
    CFG_WIDTH_LOG2   = 2'd1,
    CFG_UNUSED_2     = 2'd2,
    CFG_UNUSED_3     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    fmt_e                fmt;
    logic [WLog2W-1:0]   wlog2;
  } cfg_t;

  // interleave the low three bits: x on even bits, y on odd bits
  function automatic logic [MortonW-1:0] morton3(input logic [TileLog2-1:0] x,
                                                 input logic [TileLog2-1:0] y);
    morton3 = {y[2], x[2], y[1], x[1], y[0], x[0]};
  endfunction

endpackage

### hdl/tiled_texture_pixel_packer_top.sv
// top level of the tiled texture pixel packer: registers, handshakes, pipeline
// depends on ttpp_pkg and ttpp_pack
`timescale 1ns / 1ps

// Takes one RGBA8 pixel with its (x, y) position per transaction and returns
// one transaction with the pixel packed as RGBA8, RGBA4444 or RGB565 and its
// element index in a texture of row-major 8x8 tiles, Morton ordered inside a
// tile (x on even bits, y on odd bits), 64 elements per tile in every format.
// Throughput is one pixel per clock while the output side is not stalling.
// A pixel is registered in the input register, then in the result register,
// with the packing and index logic between them; out_valid_o comes from the
// result register. The two-entry pipeline stalls only when both stages are
// full and the output side is stalling. Configuration writes are always
// accepted (cfg_ready_o high) and should only be issued while no pixel is
// in flight. Register 0 selects the format (code 3 packs as RGBA8);
// register 1 holds log2 of the padded width, clamped to 3..10.
// Indexes that exceed 20 bits wrap; in_range_o flags x below the width.

module tiled_texture_pixel_packer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ttpp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ttpp_pkg::CfgDataW-1:0]   cfg_data_i,
  // pixel input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ttpp_pkg::PosW-1:0]       pos_x_i,
  input  logic [ttpp_pkg::PosW-1:0]       pos_y_i,
  input  logic [ttpp_pkg::ChanW-1:0]      red_i,
  input  logic [ttpp_pkg::ChanW-1:0]      green_i,
  input  logic [ttpp_pkg::ChanW-1:0]      blue_i,
  input  logic [ttpp_pkg::ChanW-1:0]      alpha_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ttpp_pkg::IndexW-1:0]     element_index_o,
  output logic [ttpp_pkg::WordW-1:0]      pixel_word_o,
  output logic                            in_range_o
);
  import ttpp_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  // input stage
  logic               s1_valid_q;
  logic [PosW-1:0]    pos_x_q, pos_y_q;
  logic [ChanW-1:0]   red_q, green_q, blue_q, alpha_q;

  // result stage
  logic               s2_valid_q;
  logic [IndexW-1:0]  element_index_q;
  logic [WordW-1:0]   pixel_word_q;
  logic               in_range_q;

  // datapath outputs
  logic [IndexW-1:0]  element_index_d;
  logic [WordW-1:0]   pixel_word_d;
  logic               in_range_d;

  logic in_accept;
  logic s1_advance;
  logic s2_free;
  logic s1_free;

  // result stage can take new data when empty or draining this cycle
  assign s2_free    = !s2_valid_q || !out_stall_i;
  assign s1_advance = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_stall_o = !s1_free;
  assign in_accept  = in_valid_i && s1_free;

  assign cfg_ready_o = 1'b1;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt   <= FMT_RGBA8;
      cfg_q.wlog2 <= WLog2W'(MinSizeLog2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PIXEL_FORMAT: cfg_q.fmt   <= fmt_e'(cfg_data_i[FmtW-1:0]);
        CFG_WIDTH_LOG2:   cfg_q.wlog2 <= cfg_data_i[WLog2W-1:0];
        default: ;
      endcase
    end
  end

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      alpha_q <= alpha_i;
    end
  end

  ttpp_pack u_pack (
    .cfg_i           (cfg_q),
    .pos_x_i         (pos_x_q),
    .pos_y_i         (pos_y_q),
    .red_i           (red_q),
    .green_i         (green_q),
    .blue_i          (blue_q),
    .alpha_i         (alpha_q),
    .element_index_o (element_index_d),
    .pixel_word_o    (pixel_word_d),
    .in_range_o      (in_range_d)
  );

  // result stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      element_index_q <= element_index_d;
      pixel_word_q    <= pixel_word_d;
      in_range_q      <= in_range_d;
    end
  end

  assign out_valid_o     = s2_valid_q;
  assign element_index_o = element_index_q;
  assign pixel_word_o    = pixel_word_q;
  assign in_range_o      = in_range_q;

  // an accepted pixel always lands in the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted pixel not captured");

  // a full, stalled pipeline keeps both pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && out_stall_i) |=> (s1_valid_q && s2_valid_q))
    else $error("pixel lost while stalled");

  // input stalls only when both stages are full and the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

endmodule

### hdl/ttpp_pack.sv
// address and pixel packing datapath, purely combinational
// depends on ttpp_pkg
`timescale 1ns / 1ps

module ttpp_pack (
  input  ttpp_pkg::cfg_t                  cfg_i,
  input  logic [ttpp_pkg::PosW-1:0]       pos_x_i,
  input  logic [ttpp_pkg::PosW-1:0]       pos_y_i,
  input  logic [ttpp_pkg::ChanW-1:0]      red_i,
  input  logic [ttpp_pkg::ChanW-1:0]      green_i,
  input  logic [ttpp_pkg::ChanW-1:0]      blue_i,
  input  logic [ttpp_pkg::ChanW-1:0]      alpha_i,
  output logic [ttpp_pkg::IndexW-1:0]     element_index_o,
  output logic [ttpp_pkg::WordW-1:0]      pixel_word_o,
  output logic                            in_range_o
);
  import ttpp_pkg::*;

  logic [WLog2W-1:0]     wl;
  logic [ShamtW-1:0]     shamt;
  logic [TileNumW-1:0]   row_base;
  logic [TileNumW-1:0]   tile_num;
  logic [PosW:0]         width;

  // clamp the width register into its legal range
  always_comb begin
    wl = cfg_i.wlog2;
    if (wl < WLog2W'(MinSizeLog2)) begin
      wl = WLog2W'(MinSizeLog2);
    end else if (wl > WLog2W'(MaxSizeLog2)) begin
      wl = WLog2W'(MaxSizeLog2);
    end
  end

  assign shamt    = ShamtW'(wl - WLog2W'(MinSizeLog2));
  assign row_base = TileNumW'(pos_y_i[PosW-1:TileLog2]) << shamt;
  assign tile_num = row_base + TileNumW'(pos_x_i[PosW-1:TileLog2]);

  assign element_index_o = {tile_num,
                            morton3(pos_x_i[TileLog2-1:0], pos_y_i[TileLog2-1:0])};

  assign width      = (PosW+1)'(1) << wl;
  assign in_range_o = ({1'b0, pos_x_i} < width);

  always_comb begin
    case (cfg_i.fmt)
      FMT_RGBA4444: pixel_word_o = {16'h0000, red_i[7:4], green_i[7:4],
                                    blue_i[7:4], alpha_i[7:4]};
      FMT_RGB565:   pixel_word_o = {16'h0000, red_i[7:3], green_i[7:2], blue_i[7:3]};
      default:      pixel_word_o = {red_i, green_i, blue_i, alpha_i};
    endcase
  end

endmodule
